>>> src/esc_pkg.sv
// ----------------------------------------------------------------------------
// esc_pkg: shared types and constants
// Coefficient layout, queue item, register codes and pipeline depths of the
// environmental sensor compensation block.
// ----------------------------------------------------------------------------
package esc_pkg;

  localparam int unsigned RAW_T_W = 20;
  localparam int unsigned RAW_P_W = 20;
  localparam int unsigned RAW_H_W = 16;
  localparam int unsigned TEMP_W  = 32;
  localparam int unsigned PRESS_W = 32;
  localparam int unsigned HUM_W   = 17;

  localparam int unsigned CFG_AW  = 6;
  localparam int unsigned CFG_DW  = 64;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam int unsigned DIV_STEPS = 64;
  localparam int unsigned P0_DLY    = 5;
  localparam int unsigned TEMP_DLY  = 79;
  localparam int unsigned HUM_DLY   = 71;
  localparam int unsigned VLD_DEPTH = 83;

  typedef enum logic [2:0] {
    REG_TEMP     = 3'd0,
    REG_PRESS_LO = 3'd1,
    REG_PRESS_HI = 3'd2,
    REG_MIXED    = 3'd3,
    REG_HUM      = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [15:0] p1;
    logic [15:0] p2;
    logic [15:0] p3;
    logic [15:0] p4;
    logic [15:0] p5;
    logic [15:0] p6;
    logic [15:0] p7;
    logic [15:0] p8;
    logic [15:0] p9;
    logic [7:0]  h1;
    logic [15:0] h2;
    logic [7:0]  h3;
    logic [15:0] h4;
    logic [15:0] h5;
    logic [7:0]  h6;
  } esc_coef_t;

  typedef struct packed {
    logic [31:0]        ta;
    logic [31:0]        td;
    logic [RAW_P_W-1:0] raw_p;
    logic [RAW_H_W-1:0] raw_h;
  } esc_item_t;

  function automatic logic [31:0] asr32(logic [31:0] x, int unsigned n);
    return $signed(x) >>> n;
  endfunction

  function automatic logic [63:0] asr64(logic [63:0] x, int unsigned n);
    return $signed(x) >>> n;
  endfunction

endpackage

>>> src/esc_if.sv
// ----------------------------------------------------------------------------
// esc_if: sample and result channels
// Valid/ready channels carrying one raw sample triple or one result triple.
// ----------------------------------------------------------------------------
interface esc_in_if;
  import esc_pkg::*;
  logic               valid;
  logic               ready;
  logic [RAW_T_W-1:0] raw_temperature;
  logic [RAW_P_W-1:0] raw_pressure;
  logic [RAW_H_W-1:0] raw_humidity;

  modport source (output valid, raw_temperature, raw_pressure, raw_humidity, input ready);
  modport sink   (input valid, raw_temperature, raw_pressure, raw_humidity, output ready);
endinterface

interface esc_out_if;
  import esc_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [TEMP_W-1:0]  temperature;
  logic        [PRESS_W-1:0] pressure;
  logic        [HUM_W-1:0]   humidity;

  modport source (output valid, temperature, pressure, humidity, input ready);
  modport sink   (input valid, temperature, pressure, humidity, output ready);
endinterface

>>> src/esc_front.sv
// ----------------------------------------------------------------------------
// esc_front: sample intake
// Takes a raw sample beat, forms the temperature differences and hands the
// item to the queue.
// ----------------------------------------------------------------------------
module esc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  esc_pkg::esc_coef_t  coef,
  esc_in_if.sink              in_ch,
  input  logic                q_ready,
  output logic                q_push,
  output esc_pkg::esc_item_t  q_item
);
  import esc_pkg::*;

  logic      valid_r, valid_nxt;
  esc_item_t item_r;
  logic      accept;

  assign in_ch.ready = !valid_r || q_ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign q_push      = valid_r && q_ready;
  assign q_item      = item_r;

  always_comb begin
    valid_nxt = valid_r && !q_ready;
    if (accept) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.ta    <= {15'b0, in_ch.raw_temperature[19:3]} - {15'b0, coef.t1, 1'b0};
      item_r.td    <= {16'b0, in_ch.raw_temperature[19:4]} - {16'b0, coef.t1};
      item_r.raw_p <= in_ch.raw_pressure;
      item_r.raw_h <= in_ch.raw_humidity;
    end
  end

endmodule

>>> src/esc_queue.sv
// ----------------------------------------------------------------------------
// esc_queue: decoupling queue
// Small FIFO between the intake and the compensation pipeline.
// ----------------------------------------------------------------------------
module esc_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  esc_pkg::esc_item_t push_item,
  output logic               ready,
  output logic               valid,
  output esc_pkg::esc_item_t item,
  input  logic               pop
);
  import esc_pkg::*;

  esc_item_t          mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]   cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign valid   = cnt_r != '0;
  assign ready   = cnt_r != (FIFO_AW+1)'(FIFO_DEPTH);
  assign item    = mem_r[rd_ptr_r];
  assign do_push = push && ready;
  assign do_pop  = pop && valid;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

>>> src/esc_mul64.sv
// ----------------------------------------------------------------------------
// esc_mul64: two-stage 64-bit wrapping multiplier
// Low 64 bits of a 64 by 64 product from three 32 by 32 partial products.
// ----------------------------------------------------------------------------
module esc_mul64 (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] p
);

  logic [63:0] pp0_r;
  logic [31:0] pp1_r, pp2_r;
  logic [63:0] p_r;

  assign p = p_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pp0_r <= 64'(a[31:0]) * 64'(b[31:0]);
      pp1_r <= a[31:0] * b[63:32];
      pp2_r <= a[63:32] * b[31:0];
      p_r   <= pp0_r + {pp1_r + pp2_r, 32'b0};
    end
  end

endmodule

>>> src/esc_div64.sv
// ----------------------------------------------------------------------------
// esc_div64: pipelined signed 64-bit divider
// Truncating signed division, one quotient bit per stage, sign fix at the end.
// ----------------------------------------------------------------------------
module esc_div64 (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] num,
  input  logic [63:0] den,
  input  logic        zero_in,
  output logic [63:0] quo,
  output logic        zero_out
);
  import esc_pkg::*;

  logic [63:0] rem_r [DIV_STEPS+1];
  logic [63:0] quo_r [DIV_STEPS+1];
  logic [63:0] den_r [DIV_STEPS+1];
  logic        neg_r [DIV_STEPS+1];
  logic        zro_r [DIV_STEPS+1];
  logic [63:0] step_rem [DIV_STEPS];
  logic [63:0] step_quo [DIV_STEPS];
  logic [63:0] q_r;
  logic        z_r;

  assign quo      = q_r;
  assign zero_out = z_r;

  always_comb begin
    logic [63:0] trial;
    logic        ge;
    for (int i = 0; i < DIV_STEPS; i++) begin
      trial       = {rem_r[i][62:0], quo_r[i][63]};
      ge          = trial >= den_r[i];
      step_rem[i] = ge ? trial - den_r[i] : trial;
      step_quo[i] = {quo_r[i][62:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= '0;
      quo_r[0] <= num[63] ? 64'd0 - num : num;
      den_r[0] <= den[63] ? 64'd0 - den : den;
      neg_r[0] <= num[63] != den[63];
      zro_r[0] <= zero_in;
      for (int i = 0; i < DIV_STEPS; i++) begin
        rem_r[i+1] <= step_rem[i];
        quo_r[i+1] <= step_quo[i];
        den_r[i+1] <= den_r[i];
        neg_r[i+1] <= neg_r[i];
        zro_r[i+1] <= zro_r[i];
      end
      q_r <= neg_r[DIV_STEPS] ? 64'd0 - quo_r[DIV_STEPS] : quo_r[DIV_STEPS];
      z_r <= zro_r[DIV_STEPS];
    end
  end

endmodule

>>> src/esc_back.sv
// ----------------------------------------------------------------------------
// esc_back: compensation pipeline
// Temperature, humidity and pressure polynomials in lock-step stages; the
// whole pipeline advances whenever the output register can take a beat.
// ----------------------------------------------------------------------------
module esc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  esc_pkg::esc_coef_t coef,
  input  logic               q_valid,
  input  esc_pkg::esc_item_t q_item,
  output logic               q_pop,
  esc_out_if.source          out_ch
);
  import esc_pkg::*;

  logic en;

  // sign-extended coefficients
  logic [31:0] t2s, t3s, h2s, h4s, h5s, h6s;
  logic [63:0] p2s, p3s, p4s, p5s, p6s, p7s, p8s, p9s;

  assign t2s = {{16{coef.t2[15]}}, coef.t2};
  assign t3s = {{16{coef.t3[15]}}, coef.t3};
  assign h2s = {{16{coef.h2[15]}}, coef.h2};
  assign h4s = {{16{coef.h4[15]}}, coef.h4};
  assign h5s = {{16{coef.h5[15]}}, coef.h5};
  assign h6s = {{24{coef.h6[7]}}, coef.h6};
  assign p2s = {{48{coef.p2[15]}}, coef.p2};
  assign p3s = {{48{coef.p3[15]}}, coef.p3};
  assign p4s = {{48{coef.p4[15]}}, coef.p4};
  assign p5s = {{48{coef.p5[15]}}, coef.p5};
  assign p6s = {{48{coef.p6[15]}}, coef.p6};
  assign p7s = {{48{coef.p7[15]}}, coef.p7};
  assign p8s = {{48{coef.p8[15]}}, coef.p8};
  assign p9s = {{48{coef.p9[15]}}, coef.p9};

  // temperature stages
  logic [31:0]        am1_r, dd1_r, a2_r, bm2_r, fine3_r, temp4_r, x4_r;
  logic [RAW_P_W-1:0] rawp1_r, rawp2_r, rawp3_r;
  logic [RAW_H_W-1:0] rawh1_r, rawh2_r, rawh3_r, rawh4_r, rawh5_r;

  // humidity stages
  logic [31:0]      m1_5_r, hb1m5_r, hb2m5_r, ha6_r, hb1_6_r, hb2_6_r;
  logic [31:0]      m2_7_r, ha7_r, m3_8_r, ha8_r, v9_r, ss10_r, v10_r, m4_11_r, v11_r;
  logic [HUM_W-1:0] hum12_r;
  logic [31:0]      s9, vh, hum_c;

  // pressure stages
  logic [63:0] v1_4_r, p0_4_r;
  logic [63:0] p0_dl_r [P0_DLY];
  logic [63:0] sq6, v1p5_6, v1p2_6, v2a8, v3p8;
  logic [63:0] v1p5_7_r, v1p2_7_r, v1p5_8_r, v1p2_8_r;
  logic [63:0] v2_9_r, v1b9_r, opc10_r, opd10_r, f12, g12, v1c13_r, pn13_r;
  logic [63:0] pq79, qs79, qq81, c2r81, c1r83;
  logic        z79, z80_r, z81_r, z82_r, z83_r;
  logic [63:0] p80_r, p81_r, p82_r, p83_r, c2r82_r, c2r83_r, press_full;

  // alignment lines and output
  logic [TEMP_W-1:0]  tdl_r [TEMP_DLY];
  logic [HUM_W-1:0]   hdl_r [HUM_DLY];
  logic               vld_r [VLD_DEPTH];
  logic               out_valid_r;
  logic [TEMP_W-1:0]  out_temp_r;
  logic [PRESS_W-1:0] out_press_r;
  logic [HUM_W-1:0]   out_hum_r;

  assign en    = !out_valid_r || out_ch.ready;
  assign q_pop = en;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.temperature = out_temp_r;
  assign out_ch.pressure    = out_press_r;
  assign out_ch.humidity    = out_hum_r;

  assign s9    = asr32(v9_r, 15);
  assign vh    = v11_r - asr32(m4_11_r, 4);
  assign hum_c = vh[31] ? 32'd0 : (vh > 32'd419430400 ? 32'd419430400 : vh);
  assign qs79  = asr64(pq79, 13);
  assign press_full = asr64(p83_r + asr64(c1r83, 25) + asr64(c2r83_r, 19), 8) + (p7s << 4);

  esc_mul64 u_mul_sq  (.clk, .en, .a(v1_4_r),  .b(v1_4_r),        .p(sq6));
  esc_mul64 u_mul_p5  (.clk, .en, .a(v1_4_r),  .b(p5s),           .p(v1p5_6));
  esc_mul64 u_mul_p2  (.clk, .en, .a(v1_4_r),  .b(p2s),           .p(v1p2_6));
  esc_mul64 u_mul_p6  (.clk, .en, .a(sq6),     .b(p6s),           .p(v2a8));
  esc_mul64 u_mul_p3  (.clk, .en, .a(sq6),     .b(p3s),           .p(v3p8));
  esc_mul64 u_mul_p1  (.clk, .en, .a(opc10_r), .b({48'b0, coef.p1}), .p(f12));
  esc_mul64 u_mul_k   (.clk, .en, .a(opd10_r), .b(64'd3125),      .p(g12));
  esc_mul64 u_mul_qq  (.clk, .en, .a(qs79),    .b(qs79),          .p(qq81));
  esc_mul64 u_mul_p8  (.clk, .en, .a(pq79),    .b(p8s),           .p(c2r81));
  esc_mul64 u_mul_p9  (.clk, .en, .a(qq81),    .b(p9s),           .p(c1r83));

  esc_div64 u_div (
    .clk,
    .en,
    .num      (pn13_r),
    .den      (v1c13_r),
    .zero_in  (v1c13_r == 64'd0),
    .quo      (pq79),
    .zero_out (z79)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      // temperature
      am1_r   <= q_item.ta * t2s;
      dd1_r   <= q_item.td * q_item.td;
      rawp1_r <= q_item.raw_p;
      rawh1_r <= q_item.raw_h;
      a2_r    <= asr32(am1_r, 11);
      bm2_r   <= asr32(dd1_r, 12) * t3s;
      rawp2_r <= rawp1_r;
      rawh2_r <= rawh1_r;
      fine3_r <= a2_r + asr32(bm2_r, 14);
      rawp3_r <= rawp2_r;
      rawh3_r <= rawh2_r;
      temp4_r <= asr32(fine3_r * 32'd5 + 32'd128, 8);
      x4_r    <= fine3_r - 32'd76800;
      v1_4_r  <= {{32{fine3_r[31]}}, fine3_r} - 64'd128000;
      p0_4_r  <= 64'd1048576 - {44'b0, rawp3_r};
      rawh4_r <= rawh3_r;

      // humidity
      m1_5_r  <= h5s * x4_r;
      hb1m5_r <= x4_r * h6s;
      hb2m5_r <= x4_r * {24'b0, coef.h3};
      rawh5_r <= rawh4_r;
      ha6_r   <= asr32({2'b0, rawh5_r, 14'b0} - {h4s[11:0], 20'b0} - m1_5_r + 32'd16384, 15);
      hb1_6_r <= asr32(hb1m5_r, 10);
      hb2_6_r <= asr32(hb2m5_r, 11) + 32'd32768;
      m2_7_r  <= hb1_6_r * hb2_6_r;
      ha7_r   <= ha6_r;
      m3_8_r  <= (asr32(m2_7_r, 10) + 32'd2097152) * h2s;
      ha8_r   <= ha7_r;
      v9_r    <= ha8_r * asr32(m3_8_r + 32'd8192, 14);
      ss10_r  <= s9 * s9;
      v10_r   <= v9_r;
      m4_11_r <= asr32(ss10_r, 7) * {24'b0, coef.h1};
      v11_r   <= v10_r;
      hum12_r <= hum_c[28:12];

      // pressure
      p0_dl_r[0] <= p0_4_r;
      for (int i = 1; i < P0_DLY; i++) begin
        p0_dl_r[i] <= p0_dl_r[i-1];
      end
      v1p5_7_r <= v1p5_6;
      v1p2_7_r <= v1p2_6;
      v1p5_8_r <= v1p5_7_r;
      v1p2_8_r <= v1p2_7_r;
      v2_9_r   <= v2a8 + (v1p5_8_r << 17) + (p4s << 35);
      v1b9_r   <= asr64(v3p8, 8) + (v1p2_8_r << 12);
      opc10_r  <= 64'h0000_8000_0000_0000 + v1b9_r;
      opd10_r  <= (p0_dl_r[P0_DLY-1] << 31) - v2_9_r;
      v1c13_r  <= asr64(f12, 33);
      pn13_r   <= g12;
      p80_r    <= pq79;
      z80_r    <= z79;
      p81_r    <= p80_r;
      z81_r    <= z80_r;
      p82_r    <= p81_r;
      z82_r    <= z81_r;
      c2r82_r  <= c2r81;
      p83_r    <= p82_r;
      z83_r    <= z82_r;
      c2r83_r  <= c2r82_r;

      // alignment and output
      tdl_r[0] <= temp4_r;
      for (int i = 1; i < TEMP_DLY; i++) begin
        tdl_r[i] <= tdl_r[i-1];
      end
      hdl_r[0] <= hum12_r;
      for (int i = 1; i < HUM_DLY; i++) begin
        hdl_r[i] <= hdl_r[i-1];
      end
      out_temp_r  <= tdl_r[TEMP_DLY-1];
      out_hum_r   <= hdl_r[HUM_DLY-1];
      out_press_r <= z83_r ? '0 : press_full[PRESS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < VLD_DEPTH; i++) begin
        vld_r[i] <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r[0] <= q_valid;
      for (int i = 1; i < VLD_DEPTH; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
      out_valid_r <= vld_r[VLD_DEPTH-1];
    end
  end

endmodule

>>> src/env_sensor_compensation.sv
// ----------------------------------------------------------------------------
// env_sensor_compensation: temperature / pressure / humidity compensation
// Applies the factory calibration polynomials to one raw sample triple.
//
// Usage:
//   in_ch   sample beats: raw_temperature, raw_pressure, raw_humidity.
//   out_ch  result beats: temperature (0.01 degC), pressure (Q24.8 Pa),
//           humidity (Q7.10 %RH, clamped), one per sample, in order.
//   cfg_*   APB-style port, 64-bit data, register i at byte address 8*i;
//           write coefficients only while no sample is in flight.
// Throughput: one sample per cycle while out_ch.ready stays high.
// Most of the path from an accepted sample beat to its result beat lies in the
//   pipelined 64-bit divider (one quotient bit per stage).
// Reset clears all coefficients to zero and empties the queue and pipeline.
// A stalled out_ch freezes the pipeline; the four-entry queue and the
// intake register keep accepting until they fill, then in_ch.ready drops.
// ----------------------------------------------------------------------------
module env_sensor_compensation (
  input  logic                       clk,
  input  logic                       rst_n,
  esc_in_if.sink                     in_ch,
  esc_out_if.source                  out_ch,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [esc_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [esc_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [esc_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                       cfg_pready
);
  import esc_pkg::*;

  logic [47:0] temp_coeffs_r;
  logic [63:0] press_lo_r;
  logic [63:0] press_hi_r;
  logic [47:0] mixed_coeffs_r;
  logic [39:0] hum_coeffs_r;
  logic [2:0]  reg_idx;
  logic        cfg_wr;
  esc_coef_t   coef;

  logic      f_push, q_ready, q_valid, q_pop;
  esc_item_t f_item, q_item;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_idx    = cfg_paddr[CFG_AW-1:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_coeffs_r  <= '0;
      press_lo_r     <= '0;
      press_hi_r     <= '0;
      mixed_coeffs_r <= '0;
      hum_coeffs_r   <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_TEMP:     temp_coeffs_r  <= cfg_pwdata[47:0];
        REG_PRESS_LO: press_lo_r     <= cfg_pwdata;
        REG_PRESS_HI: press_hi_r     <= cfg_pwdata;
        REG_MIXED:    mixed_coeffs_r <= cfg_pwdata[47:0];
        REG_HUM:      hum_coeffs_r   <= cfg_pwdata[39:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_TEMP:     cfg_prdata = {16'b0, temp_coeffs_r};
      REG_PRESS_LO: cfg_prdata = press_lo_r;
      REG_PRESS_HI: cfg_prdata = press_hi_r;
      REG_MIXED:    cfg_prdata = {16'b0, mixed_coeffs_r};
      REG_HUM:      cfg_prdata = {24'b0, hum_coeffs_r};
      default:      cfg_prdata = '0;
    endcase
  end

  always_comb begin
    coef.t1 = temp_coeffs_r[15:0];
    coef.t2 = temp_coeffs_r[31:16];
    coef.t3 = temp_coeffs_r[47:32];
    coef.p1 = press_lo_r[15:0];
    coef.p2 = press_lo_r[31:16];
    coef.p3 = press_lo_r[47:32];
    coef.p4 = press_lo_r[63:48];
    coef.p5 = press_hi_r[15:0];
    coef.p6 = press_hi_r[31:16];
    coef.p7 = press_hi_r[47:32];
    coef.p8 = press_hi_r[63:48];
    coef.p9 = mixed_coeffs_r[15:0];
    coef.h1 = mixed_coeffs_r[23:16];
    coef.h2 = mixed_coeffs_r[39:24];
    coef.h3 = mixed_coeffs_r[47:40];
    coef.h4 = hum_coeffs_r[15:0];
    coef.h5 = hum_coeffs_r[31:16];
    coef.h6 = hum_coeffs_r[39:32];
  end

  esc_front u_front (
    .clk,
    .rst_n,
    .coef,
    .in_ch,
    .q_ready,
    .q_push (f_push),
    .q_item (f_item)
  );

  esc_queue u_queue (
    .clk,
    .rst_n,
    .push      (f_push),
    .push_item (f_item),
    .ready     (q_ready),
    .valid     (q_valid),
    .item      (q_item),
    .pop       (q_pop)
  );

  esc_back u_back (
    .clk,
    .rst_n,
    .coef,
    .q_valid,
    .q_item,
    .q_pop,
    .out_ch
  );

endmodule

>>> tb/sv/tb_env_sensor_compensation.sv
// ----------------------------------------------------------------------------
// tb_env_sensor_compensation: compensation block regression
// Programs coefficient sets over the APB-style port, sends raw sample beats
// with random gaps and output stalls, and compares every result beat against
// a bit-true integer model of the calibration polynomials.
// ----------------------------------------------------------------------------
class esc_scoreboard;
  logic [31:0] exp_temp[$];
  logic [31:0] exp_press[$];
  logic [16:0] exp_hum[$];
  logic [63:0] coef[5];
  int errors;

  function new();
    errors = 0;
    foreach (coef[i]) coef[i] = '0;
  endfunction

  function automatic logic [63:0] sx(logic [63:0] v, int pos, int bits);
    logic [63:0] f;
    logic [63:0] s;
    f = (v >> pos) & ((64'd1 << bits) - 64'd1);
    s = 64'd1 << (bits - 1);
    return (f ^ s) - s;
  endfunction

  function automatic logic [31:0] sr32(logic [31:0] x, int n);
    return $signed(x) >>> n;
  endfunction

  function automatic logic [63:0] sr64(logic [63:0] x, int n);
    return $signed(x) >>> n;
  endfunction

  function void note_sample(logic [19:0] rt, logic [19:0] rp, logic [15:0] rh);
    logic [31:0] t1, t2, t3, h1, h2, h3, h4, h5, h6;
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] a, d, b, fine, temp, x, ha, hb1, hb2, hb, v, s;
    logic [63:0] f64, v1, v2, p, q, c1, c2, press, an, ad;
    logic nn, nd;
    t1 = 32'(coef[0][15:0]);
    t2 = 32'(sx(coef[0], 16, 16));
    t3 = 32'(sx(coef[0], 32, 16));
    p1 = 64'(coef[1][15:0]);
    p2 = sx(coef[1], 16, 16);
    p3 = sx(coef[1], 32, 16);
    p4 = sx(coef[1], 48, 16);
    p5 = sx(coef[2], 0, 16);
    p6 = sx(coef[2], 16, 16);
    p7 = sx(coef[2], 32, 16);
    p8 = sx(coef[2], 48, 16);
    p9 = sx(coef[3], 0, 16);
    h1 = 32'(coef[3][23:16]);
    h2 = 32'(sx(coef[3], 24, 16));
    h3 = 32'(coef[3][47:40]);
    h4 = 32'(sx(coef[4], 0, 16));
    h5 = 32'(sx(coef[4], 16, 16));
    h6 = 32'(sx(coef[4], 32, 8));
    a = sr32(((32'(rt) >> 3) - (t1 << 1)) * t2, 11);
    d = (32'(rt) >> 4) - t1;
    b = sr32(sr32(d * d, 12) * t3, 14);
    fine = a + b;
    temp = sr32(fine * 32'd5 + 32'd128, 8);
    x = fine - 32'd76800;
    ha = sr32((32'(rh) << 14) - (h4 << 20) - h5 * x + 32'd16384, 15);
    hb1 = sr32(x * h6, 10);
    hb2 = sr32(x * h3, 11) + 32'd32768;
    hb = sr32((sr32(hb1 * hb2, 10) + 32'd2097152) * h2 + 32'd8192, 14);
    v = ha * hb;
    s = sr32(v, 15);
    v = v - sr32(sr32(s * s, 7) * h1, 4);
    if (v[31]) v = '0;
    else if (v > 32'd419430400) v = 32'd419430400;
    f64 = {{32{fine[31]}}, fine};
    v1 = f64 - 64'd128000;
    v2 = v1 * v1 * p6;
    v2 = v2 + ((v1 * p5) << 17);
    v2 = v2 + (p4 << 35);
    v1 = sr64(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
    v1 = sr64(((64'd1 << 47) + v1) * p1, 33);
    press = '0;
    if (v1 != 64'd0) begin
      p = 64'd1048576 - 64'(rp);
      p = ((p << 31) - v2) * 64'd3125;
      nn = p[63];
      nd = v1[63];
      an = nn ? -p : p;
      ad = nd ? -v1 : v1;
      p = an / ad;
      if (nn != nd) p = -p;
      q = sr64(p, 13);
      c1 = sr64(p9 * q * q, 25);
      c2 = sr64(p8 * p, 19);
      p = sr64(p + c1 + c2, 8) + (p7 << 4);
      press = p & 64'hFFFF_FFFF;
    end
    exp_temp.push_back(temp);
    exp_press.push_back(press[31:0]);
    exp_hum.push_back(17'(v >> 12));
  endfunction

  function void check_result(logic [31:0] t, logic [31:0] p, logic [16:0] h);
    logic [31:0] et, ep;
    logic [16:0] eh;
    if (exp_temp.size() == 0) begin
      $display("%0t unexpected result beat t=%h p=%h h=%h", $time, t, p, h);
      errors++;
      return;
    end
    et = exp_temp.pop_front();
    ep = exp_press.pop_front();
    eh = exp_hum.pop_front();
    if (t !== et) begin
      $display("%0t temperature exp %h got %h", $time, et, t);
      errors++;
    end
    if (p !== ep) begin
      $display("%0t pressure exp %h got %h", $time, ep, p);
      errors++;
    end
    if (h !== eh) begin
      $display("%0t humidity exp %h got %h", $time, eh, h);
      errors++;
    end
  endfunction

  function int pending();
    return exp_temp.size();
  endfunction
endclass

module tb_env_sensor_compensation;
  import esc_pkg::*;

  localparam int LATENCY = 86;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [CFG_DW-1:0] cfg_pwdata = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic cfg_pready;
  int cycles = 0;
  bit hold_off = 0;

  esc_in_if in_ch ();
  esc_out_if out_ch ();

  esc_scoreboard sb = new();

  env_sensor_compensation u_top (
    .clk, .rst_n, .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_prdata, .cfg_pready
  );

  initial begin
    in_ch.valid = 0;
    in_ch.raw_temperature = '0;
    in_ch.raw_pressure = '0;
    in_ch.raw_humidity = '0;
    out_ch.ready = 0;
  end

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver: random wait per beat, plus a long hold-off on request
  initial begin : sink_proc
    int w;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_off) begin
        out_ch.ready <= 0;
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      if (w > 0) begin
        out_ch.ready <= 0;
        repeat (w) @(posedge clk);
      end
      out_ch.ready <= 1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      sb.check_result(out_ch.temperature, out_ch.pressure, out_ch.humidity);
    end
  end

  task automatic cfg_write(reg_idx_t idx, logic [63:0] val);
    cfg_psel <= 1;
    cfg_penable <= 0;
    cfg_pwrite <= 1;
    cfg_paddr <= CFG_AW'(idx) << 3;
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk iff cfg_pready);
    cfg_psel <= 0;
    cfg_penable <= 0;
    cfg_pwrite <= 0;
    case (idx)
      REG_TEMP, REG_MIXED: sb.coef[idx] = val & 64'hFFFF_FFFF_FFFF;
      REG_HUM: sb.coef[idx] = val & 64'hFF_FFFF_FFFF;
      default: sb.coef[idx] = val;
    endcase
  endtask

  task automatic send_sample(logic [19:0] rt, logic [19:0] rp, logic [15:0] rh, bit gaps);
    int g;
    g = gaps ? (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 8)) : 0;
    if (g > 0) begin
      in_ch.valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.raw_temperature <= rt;
    in_ch.raw_pressure <= rp;
    in_ch.raw_humidity <= rh;
    @(posedge clk iff in_ch.ready);
    sb.note_sample(rt, rp, rh);
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    @(posedge clk iff sb.pending() == 0);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  // realistic factory-like coefficients with random perturbation
  task automatic load_typical();
    cfg_write(REG_TEMP, {16'($signed(50) + $urandom_range(0, 20)),
      16'(26000 + $urandom_range(0, 2000)), 16'(27000 + $urandom_range(0, 2000))});
    cfg_write(REG_PRESS_LO, {16'(7000 + $urandom_range(0, 2000)), 16'(-16'sd4700),
      16'(-16'sd10600 - 16'($urandom_range(0, 200))), 16'(36000 + $urandom_range(0, 2000))});
    cfg_write(REG_PRESS_HI, {16'(-16'sd12000), 16'(15500), 16'(-16'sd7), 16'(100 + $urandom_range(0, 200))});
    cfg_write(REG_MIXED, {8'd0, 16'(300 + $urandom_range(0, 100)), 8'd75, 16'(6000)});
    cfg_write(REG_HUM, {8'd30, 16'(50), 16'(300 + $urandom_range(0, 60))});
  endtask

  task automatic load_random();
    cfg_write(REG_TEMP, {$urandom, $urandom});
    cfg_write(REG_PRESS_LO, {$urandom, $urandom});
    cfg_write(REG_PRESS_HI, {$urandom, $urandom});
    cfg_write(REG_MIXED, {$urandom, $urandom});
    cfg_write(REG_HUM, {$urandom, $urandom});
  endtask

  task automatic load_all(logic [63:0] val);
    cfg_write(REG_TEMP, val);
    cfg_write(REG_PRESS_LO, val);
    cfg_write(REG_PRESS_HI, val);
    cfg_write(REG_MIXED, val);
    cfg_write(REG_HUM, val);
  endtask

  task automatic random_burst(int n, bit real_range);
    for (int i = 0; i < n; i++) begin
      if (real_range && $urandom_range(0, 4) != 0)
        send_sample(20'($urandom_range(400000, 600000)), 20'($urandom_range(250000, 450000)),
                    16'($urandom_range(20000, 40000)), 1);
      else
        send_sample(20'($urandom), 20'($urandom), 16'($urandom), 1);
    end
  endtask

  initial begin : main_proc
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // zero coefficients: divisor zero
    send_sample(20'd0, 20'd0, 16'd0, 0);
    send_sample(20'hFFFFF, 20'hFFFFF, 16'hFFFF, 0);
    drain();

    load_typical();
    send_sample(20'd519888, 20'd415148, 16'd28000, 0);
    send_sample(20'd0, 20'd0, 16'd0, 0);
    send_sample(20'hFFFFF, 20'hFFFFF, 16'hFFFF, 0);
    send_sample(20'hFFFFF, 20'd0, 16'd0, 0);
    send_sample(20'd0, 20'hFFFFF, 16'hFFFF, 0);
    send_sample(20'd300000, 20'd500000, 16'd60000, 0);
    send_sample(20'd700000, 20'd100000, 16'd1000, 0);
    drain();

    load_all(64'hFFFF_FFFF_FFFF_FFFF);
    send_sample(20'd0, 20'd0, 16'd0, 0);
    send_sample(20'hFFFFF, 20'hFFFFF, 16'hFFFF, 0);
    send_sample(20'h80000, 20'h80000, 16'h8000, 0);
    drain();

    load_all(64'h8000_8000_8000_8000);
    send_sample(20'd0, 20'hFFFFF, 16'd0, 0);
    send_sample(20'hFFFFF, 20'd0, 16'hFFFF, 0);
    drain();

    // fill the block under a long output hold-off
    load_typical();
    hold_off = 1;
    random_burst(40, 1);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      if (ph % 2 == 0) load_typical();
      else load_random();
      random_burst(220, ph % 2 == 0);
      drain();
    end

    if (sb.errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule

>>> env_sensor_compensation.f
src/esc_pkg.sv
src/esc_if.sv
src/esc_front.sv
src/esc_queue.sv
src/esc_mul64.sv
src/esc_div64.sv
src/esc_back.sv
src/env_sensor_compensation.sv
tb/sv/tb_env_sensor_compensation.sv
